>>> design/qgi_pkg.sv
// Shared constants, types and the cross-product term table of the
// quaternion gyro integrator. No dependencies.
`default_nettype none
package qgi_pkg;

    localparam int QUAT_FRAC_BITS = 30;
    localparam logic [31:0] TIME_STEP_RESET = 32'd42949673;
    localparam logic [31:0] QUAT_ONE = 32'(64'd1 << QUAT_FRAC_BITS);

    localparam int MAG_W  = 41;          // multiplier A operand, magnitudes
    localparam int PROD_W = MAG_W + 16;  // one partial product
    localparam int ACC_W  = MAG_W + 32;  // full product

    typedef enum logic {
        SD_ROOT = 1'b0,
        SD_DIV  = 1'b1
    } sd_mode_t;

    typedef struct packed {
        logic     start;
        sd_mode_t mode;
    } sd_ctl_t;

    typedef struct packed {
        logic done;
    } sd_stat_t;

    // One product term of q (x) (0,g): target component, q and g indexes, sign
    typedef struct packed {
        logic [1:0] comp;
        logic [1:0] qsel;
        logic [1:0] gsel;
        logic       neg;
    } term_t;

    function automatic term_t term_lut(input logic [3:0] idx);
        term_t t;
        unique case (idx)
            4'd0:    t = '{comp: 2'd0, qsel: 2'd1, gsel: 2'd0, neg: 1'b1};
            4'd1:    t = '{comp: 2'd0, qsel: 2'd2, gsel: 2'd1, neg: 1'b1};
            4'd2:    t = '{comp: 2'd0, qsel: 2'd3, gsel: 2'd2, neg: 1'b1};
            4'd3:    t = '{comp: 2'd1, qsel: 2'd0, gsel: 2'd0, neg: 1'b0};
            4'd4:    t = '{comp: 2'd1, qsel: 2'd2, gsel: 2'd2, neg: 1'b0};
            4'd5:    t = '{comp: 2'd1, qsel: 2'd3, gsel: 2'd1, neg: 1'b1};
            4'd6:    t = '{comp: 2'd2, qsel: 2'd0, gsel: 2'd1, neg: 1'b0};
            4'd7:    t = '{comp: 2'd2, qsel: 2'd1, gsel: 2'd2, neg: 1'b1};
            4'd8:    t = '{comp: 2'd2, qsel: 2'd3, gsel: 2'd0, neg: 1'b0};
            4'd9:    t = '{comp: 2'd3, qsel: 2'd0, gsel: 2'd2, neg: 1'b0};
            4'd10:   t = '{comp: 2'd3, qsel: 2'd1, gsel: 2'd1, neg: 1'b0};
            4'd11:   t = '{comp: 2'd3, qsel: 2'd2, gsel: 2'd0, neg: 1'b1};
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

>>> design/qgi_mul.sv
// Shared 41x16 unsigned multiplier with registered product.
// Depends on qgi_pkg.
`default_nettype none
module qgi_mul (
    input  wire logic                      aclk,
    input  wire logic [qgi_pkg::MAG_W-1:0] op_a,
    input  wire logic [15:0]               op_b,
    output logic [qgi_pkg::PROD_W-1:0]     prod_reg
);
    import qgi_pkg::*;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

endmodule
`default_nettype wire

>>> design/qgi_sqdiv.sv
// Bit-serial unit: 64-bit integer square root or 33-bit quotient division,
// both on one shared compare-subtract. Depends on qgi_pkg.
`default_nettype none
module qgi_sqdiv (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire qgi_pkg::sd_ctl_t ctl,
    input  wire logic [63:0]      op_a,
    input  wire logic [31:0]      op_b,
    output qgi_pkg::sd_stat_t     stat,
    output logic [63:0]           result
);
    import qgi_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    sd_mode_t    mode_reg, mode_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] one_reg, one_next;
    logic [31:0] dvsr_reg, dvsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] sa, sb;
    logic [64:0] diff;
    logic        ge;

    // shared compare-subtract
    always_comb begin
        if (mode_reg == SD_ROOT) begin
            sa = v_reg;
            sb = res_reg + one_reg;
        end else begin
            sa = {31'b0, v_reg[31:0], one_reg[32]};
            sb = {32'b0, dvsr_reg};
        end
        diff = {1'b0, sa} - {1'b0, sb};
        ge   = !diff[64];
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        one_next  = one_reg;
        dvsr_next = dvsr_reg;
        cnt_next  = cnt_reg;
        if (ctl.start) begin
            busy_next = 1'b1;
            mode_next = ctl.mode;
            res_next  = '0;
            dvsr_next = op_b;
            if (ctl.mode == SD_ROOT) begin
                v_next   = op_a;
                one_next = 64'd1 << 62;
                cnt_next = 6'd31;
            end else begin
                v_next   = op_a >> 33;
                one_next = op_a;
                cnt_next = 6'd32;
            end
        end else if (busy_reg) begin
            if (mode_reg == SD_ROOT) begin
                if (ge) begin
                    v_next   = diff[63:0];
                    res_next = (res_reg >> 1) + one_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                one_next = one_reg >> 2;
            end else begin
                v_next   = ge ? diff[63:0] : sa;
                res_next = {res_reg[62:0], ge};
                one_next = one_reg << 1;
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= SD_ROOT;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg    <= v_next;
        res_reg  <= res_next;
        one_reg  <= one_next;
        dvsr_reg <= dvsr_next;
    end

    assign stat.done = done_reg;
    assign result    = res_reg;

endmodule
`default_nettype wire

>>> design/quaternion_gyro_integrator.sv
// Quaternion gyro integrator: first-order update q + dt/2 * q (x) w, then
// renormalization. Depends on qgi_pkg, qgi_mul and qgi_sqdiv.
// Steps from an accepted word to a valid result: cross terms, dt scale,
// pre-scale, squares, root and four divides; an all-zero sum skips to the
// end from the pre-scale.
// One sample at a time: s_tready is high only in ST_IDLE, after the last
// result is loaded into the output register. A result waits in the output
// register while the next sample is taken. Reset sets identity and dt = 0.01 s.
`default_nettype none
module quaternion_gyro_integrator (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // config write: time_step, unsigned Q0.32
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [31:0]  cfg_data,
    // input word
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,   // rate_x, rate_y, rate_z (lowest first)
    // result word
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata    // quat_w, quat_x, quat_y, quat_z
);
    import qgi_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_TERM = 8'b0000_0010,
        ST_STEP = 8'b0000_0100,
        ST_NORM = 8'b0000_1000,
        ST_SQ   = 8'b0001_0000,
        ST_ROOT = 8'b0010_0000,
        ST_DIV  = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

    localparam logic [4:0] TERM_LAST = 5'd24;  // 12 products, two halves each
    localparam logic [4:0] QUAD_LAST = 5'd8;   // 4 products, two halves each

    state_t state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [1:0]  di_reg, di_next;
    logic [31:0] time_step_reg, time_step_next;
    logic signed [31:0] orient_reg [4];
    logic signed [31:0] orient_next [4];
    logic signed [31:0] rate_reg [3];
    logic signed [31:0] rate_next [3];
    logic signed [MAG_W-1:0] s_reg [4];
    logic signed [MAG_W-1:0] s_next [4];
    logic [MAG_W-1:0] mag_reg [4];
    logic [MAG_W-1:0] mag_next [4];
    logic [3:0]  neg_reg, neg_next;
    logic [MAG_W-1:0] mx_reg, mx_next;
    logic [63:0] sum_reg, sum_next;
    logic [31:0] r_reg, r_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic        start_reg, start_next;
    sd_mode_t    mode_reg, mode_next;
    logic        out_valid_reg, out_valid_next;
    logic [127:0] out_data_reg, out_data_next;

    // multiplier operands and collected result
    logic [MAG_W-1:0] mul_a;
    logic [31:0]      mul_b;
    logic [PROD_W-1:0] prod;
    logic [4:0]  cnt_m1;
    logic [3:0]  pc;
    logic        collect;
    logic [ACC_W-1:0] full, rnd;
    term_t       iss_term, col_term;
    logic [MAG_W-1:0] m_rnd;
    logic        t_sgn;
    logic signed [MAG_W+1:0] p_val;
    logic [MAG_W-1:0] p_mag;
    sd_ctl_t     sd_ctl;
    sd_stat_t    sd_stat;
    logic [63:0] sd_op_a, sd_res;
    logic [32:0] quo;
    logic signed [33:0] qv;
    logic signed [31:0] qsat;
    logic        out_load;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // operand select for the shared multiplier: high half of B first
    always_comb begin
        iss_term = term_lut(cnt_reg[4:1]);
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_TERM: begin
                mul_a = MAG_W'(orient_reg[iss_term.qsel][31] ?
                               32'(-orient_reg[iss_term.qsel]) :
                               32'(orient_reg[iss_term.qsel]));
                mul_b = rate_reg[iss_term.gsel][31] ? 32'(-rate_reg[iss_term.gsel]) :
                                                      32'(rate_reg[iss_term.gsel]);
            end
            ST_STEP: begin
                mul_a = s_reg[cnt_reg[2:1]][MAG_W-1] ?
                        MAG_W'(-s_reg[cnt_reg[2:1]]) : MAG_W'(s_reg[cnt_reg[2:1]]);
                mul_b = time_step_reg;
            end
            ST_SQ: begin
                mul_a = MAG_W'(mag_reg[cnt_reg[2:1]][30:0]);
                mul_b = 32'(mag_reg[cnt_reg[2:1]][30:0]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    qgi_mul u_mul (
        .aclk     (aclk),
        .op_a     (mul_a),
        .op_b     (cnt_reg[0] ? mul_b[15:0] : mul_b[31:16]),
        .prod_reg (prod)
    );

    // collect side: the product issued in the previous cycle
    always_comb begin
        cnt_m1   = cnt_reg - 5'd1;
        pc       = cnt_m1[4:1];
        collect  = (cnt_reg != '0) && cnt_m1[0];
        full     = acc_reg + ACC_W'(prod);
        col_term = term_lut(pc);
        if (state_reg == ST_STEP) begin
            rnd   = full + (ACC_W'(1) << 32);
            m_rnd = MAG_W'(rnd[ACC_W-1:33]);
        end else begin
            rnd   = full + (ACC_W'(1) << 23);
            m_rnd = MAG_W'(rnd[ACC_W-1:24]);
        end
        t_sgn = col_term.neg ^ orient_reg[col_term.qsel][31] ^
                rate_reg[col_term.gsel][31];
        p_val = (MAG_W+2)'(orient_reg[pc[1:0]]) +
                (s_reg[pc[1:0]][MAG_W-1] ? -$signed({2'b00, m_rnd})
                                         :  $signed({2'b00, m_rnd}));
        p_mag = p_val[MAG_W+1] ? MAG_W'(-p_val) : MAG_W'(p_val);
    end

    // root/divide operands; divide works on magnitude << F plus half divisor
    assign sd_op_a = (state_reg == ST_ROOT) ? sum_reg :
                     ((64'(mag_reg[di_reg][30:0]) << QUAT_FRAC_BITS) + 64'(r_reg >> 1));
    assign sd_ctl = '{start: start_reg, mode: mode_reg};

    qgi_sqdiv u_sqdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (sd_ctl),
        .op_a    (sd_op_a),
        .op_b    (r_reg),
        .stat    (sd_stat),
        .result  (sd_res)
    );

    // restore sign and saturate the quotient
    always_comb begin
        quo  = sd_res[32:0];
        qv   = neg_reg[di_reg] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        if (qv > 34'sd2147483647) begin
            qsat = 32'sh7FFF_FFFF;
        end else if (qv < -34'sd2147483648) begin
            qsat = 32'sh8000_0000;
        end else begin
            qsat = 32'(qv);
        end
    end

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        di_next        = di_reg;
        time_step_next = (cfg_valid && cfg_ready) ? cfg_data : time_step_reg;
        orient_next    = orient_reg;
        rate_next      = rate_reg;
        s_next         = s_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        mx_next        = mx_reg;
        sum_next       = sum_reg;
        r_next         = r_reg;
        acc_next       = acc_reg;
        start_next     = 1'b0;
        mode_next      = mode_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;

        // first half of each product: hold high part, shifted
        if (cnt_reg != '0 && !cnt_m1[0]) begin
            acc_next = ACC_W'(prod) << 16;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    rate_next[0] = s_tdata[31:0];
                    rate_next[1] = s_tdata[63:32];
                    rate_next[2] = s_tdata[95:64];
                    for (int i = 0; i < 4; i++) begin
                        s_next[i] = '0;
                    end
                    cnt_next   = '0;
                    state_next = ST_TERM;
                end
            end
            ST_TERM: begin
                if (collect) begin
                    s_next[col_term.comp] = s_reg[col_term.comp] +
                        (t_sgn ? -$signed(m_rnd) : $signed(m_rnd));
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == TERM_LAST) begin
                    cnt_next   = '0;
                    mx_next    = '0;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (collect) begin
                    mag_next[pc[1:0]] = p_mag;
                    neg_next[pc[1:0]] = p_val[MAG_W+1];
                    if (p_mag > mx_reg) begin
                        mx_next = p_mag;
                    end
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == QUAD_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                // bring the largest magnitude into [2^30, 2^31)
                if (mx_reg == '0) begin
                    orient_next[0] = QUAT_ONE;
                    for (int i = 1; i < 4; i++) begin
                        orient_next[i] = '0;
                    end
                    state_next = ST_DONE;
                end else if (mx_reg >= (MAG_W'(1) << 35)) begin
                    mx_next = mx_reg >> 4;
                    for (int i = 0; i < 4; i++) begin
                        mag_next[i] = mag_reg[i] >> 4;
                    end
                end else if (mx_reg >= (MAG_W'(1) << 31)) begin
                    mx_next = mx_reg >> 1;
                    for (int i = 0; i < 4; i++) begin
                        mag_next[i] = mag_reg[i] >> 1;
                    end
                end else if (mx_reg < (MAG_W'(1) << 26)) begin
                    mx_next = mx_reg << 4;
                    for (int i = 0; i < 4; i++) begin
                        mag_next[i] = mag_reg[i] << 4;
                    end
                end else if (mx_reg < (MAG_W'(1) << 30)) begin
                    mx_next = mx_reg << 1;
                    for (int i = 0; i < 4; i++) begin
                        mag_next[i] = mag_reg[i] << 1;
                    end
                end else begin
                    sum_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                if (collect) begin
                    sum_next = sum_reg + full[63:0];
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == QUAD_LAST) begin
                    cnt_next   = '0;
                    start_next = 1'b1;
                    mode_next  = SD_ROOT;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (sd_stat.done) begin
                    r_next     = sd_res[31:0];
                    di_next    = '0;
                    start_next = 1'b1;
                    mode_next  = SD_DIV;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (sd_stat.done) begin
                    orient_next[di_reg] = qsat;
                    if (di_reg == 2'd3) begin
                        state_next = ST_DONE;
                    end else begin
                        di_next    = di_reg + 2'd1;
                        start_next = 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {orient_reg[3], orient_reg[2],
                                      orient_reg[1], orient_reg[0]};
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            di_reg        <= '0;
            start_reg     <= 1'b0;
            mode_reg      <= SD_ROOT;
            out_valid_reg <= 1'b0;
            time_step_reg <= TIME_STEP_RESET;
            orient_reg[0] <= QUAT_ONE;
            orient_reg[1] <= '0;
            orient_reg[2] <= '0;
            orient_reg[3] <= '0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            di_reg        <= di_next;
            start_reg     <= start_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
            time_step_reg <= time_step_next;
            orient_reg    <= orient_next;
        end
    end

    always_ff @(posedge aclk) begin
        rate_reg     <= rate_next;
        s_reg        <= s_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        mx_reg       <= mx_next;
        sum_reg      <= sum_next;
        r_reg        <= r_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

endmodule
`default_nettype wire
